### design/csstl_pkg.sv
package csstl_pkg;

    // Width of the internal line and column counters; they saturate at all ones.
    localparam int POSITION_WIDTH = 16;
    // Number of result records the queue between front and back can hold.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_WIDTH     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] KIND_WS        = 4'd0;
    localparam logic [3:0] KIND_IDENT     = 4'd1;
    localparam logic [3:0] KIND_NUMBER    = 4'd2;
    localparam logic [3:0] KIND_STRING    = 4'd3;
    localparam logic [3:0] KIND_DELIM     = 4'd4;
    localparam logic [3:0] KIND_COLON     = 4'd5;
    localparam logic [3:0] KIND_SEMICOLON = 4'd6;
    localparam logic [3:0] KIND_COMMA     = 4'd7;
    localparam logic [3:0] KIND_LBRACE    = 4'd8;
    localparam logic [3:0] KIND_RBRACE    = 4'd9;
    localparam logic [3:0] KIND_LPAREN    = 4'd10;
    localparam logic [3:0] KIND_RPAREN    = 4'd11;
    localparam logic [3:0] KIND_CHILD     = 4'd12;
    localparam logic [3:0] KIND_UNIVERSAL = 4'd13;
    localparam logic [3:0] KIND_EOF       = 4'd14;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  value_byte;
        logic        has_byte;
        logic        token_start;
        logic        token_end;
        logic [15:0] start_line;
        logic [15:0] start_column;
    } result_t;

    // One accepted character yields at most two results: the token byte of the
    // held character and, on an end item, the end-of-file token.
    typedef struct packed {
        result_t r0;
        logic    r1_valid;
        result_t r1;
    } rec_t;

    // Clamp an internal position to the 16-bit output field.
    function automatic logic [15:0] clamp_pos(input logic [POSITION_WIDTH-1:0] p);
        logic [31:0] w;
        begin
            w = 32'(p);
            clamp_pos = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
        end
    endfunction

endpackage

### design/csstl_front.sv
module csstl_front
    import csstl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  push_valid,
    input  logic  push_ready,
    output rec_t  push_data
);

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_WS        = 4'd1;
    localparam logic [3:0] M_IDENT     = 4'd2;
    localparam logic [3:0] M_NUMBER    = 4'd3;
    localparam logic [3:0] M_STR_FIRST = 4'd4;
    localparam logic [3:0] M_STR       = 4'd5;
    localparam logic [3:0] M_ESC_FIRST = 4'd6;
    localparam logic [3:0] M_ESC       = 4'd7;
    localparam logic [3:0] M_STR_CLOSE = 4'd8;
    localparam logic [3:0] M_CMT_OPEN  = 4'd9;
    localparam logic [3:0] M_CMT       = 4'd10;
    localparam logic [3:0] M_CMT_CLOSE = 4'd11;

    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

    function automatic logic is_ws(input logic [7:0] x);
        is_ws = (x == 8'h20) || (x == 8'h09) || (x == 8'h0A) || (x == 8'h0D)
             || (x == 8'h0C);
    endfunction

    function automatic logic is_digit(input logic [7:0] x);
        is_digit = (x >= 8'h30) && (x <= 8'h39);
    endfunction

    function automatic logic is_id_start(input logic [7:0] x);
        is_id_start = ((x >= 8'h61) && (x <= 8'h7A)) || ((x >= 8'h41) && (x <= 8'h5A))
                   || (x == 8'h5F) || (x == 8'h2D) || (x == 8'h23) || (x == 8'h2E);
    endfunction

    function automatic logic [3:0] delim_kind(input logic [7:0] x);
        logic [3:0] k;
        begin
            unique case (x)
                8'h3A:   k = KIND_COLON;
                8'h3B:   k = KIND_SEMICOLON;
                8'h2C:   k = KIND_COMMA;
                8'h7B:   k = KIND_LBRACE;
                8'h7D:   k = KIND_RBRACE;
                8'h28:   k = KIND_LPAREN;
                8'h29:   k = KIND_RPAREN;
                8'h3E:   k = KIND_CHILD;
                8'h2A:   k = KIND_UNIVERSAL;
                default: k = KIND_DELIM;
            endcase
            delim_kind = k;
        end
    endfunction

    logic [3:0]                mode_reg, mode_next;
    logic [7:0]                held_reg, held_next;
    logic                      held_valid_reg, held_valid_next;
    logic [7:0]                quote_reg, quote_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;
    logic [POSITION_WIDTH-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_WIDTH-1:0] tok_col_reg, tok_col_next;

    logic [7:0]                h, c;
    logic                      cv;
    logic                      fire;
    logic                      p_emit, p_has, p_st, p_en, cont, ends;
    logic [3:0]                p_kind, p_mode;
    logic [7:0]                p_byte, p_quote;
    logic [POSITION_WIDTH-1:0] p_tl, p_tc, adv_line, adv_col, eof_line, eof_col;
    result_t                   p_res, eof_res;

    assign h    = held_reg;
    assign c    = item.ch;
    assign cv   = !item.end_of_input;
    assign fire = item_valid && item_ready;

    // Input is taken whenever the queue has room for a record.
    assign item_ready = push_ready;

    // Classify the held character against the incoming lookahead.
    always_comb
    begin
        p_emit  = 1'b0;
        p_kind  = KIND_WS;
        p_byte  = h;
        p_has   = 1'b1;
        p_st    = 1'b0;
        p_en    = 1'b0;
        p_mode  = mode_reg;
        p_quote = quote_reg;
        p_tl    = tok_line_reg;
        p_tc    = tok_col_reg;
        cont    = 1'b0;
        ends    = !cv || (c == quote_reg);
        unique case (mode_reg)
            M_WS:
            begin
                cont   = cv && is_ws(c);
                p_emit = 1'b1;
                p_kind = KIND_WS;
                p_en   = !cont;
                p_mode = cont ? M_WS : M_IDLE;
            end
            M_IDENT:
            begin
                cont   = cv && (is_id_start(c) || is_digit(c));
                p_emit = 1'b1;
                p_kind = KIND_IDENT;
                p_en   = !cont;
                p_mode = cont ? M_IDENT : M_IDLE;
            end
            M_NUMBER:
            begin
                cont   = cv && (is_digit(c) || (c == 8'h2E));
                p_emit = 1'b1;
                p_kind = KIND_NUMBER;
                p_en   = !cont;
                p_mode = cont ? M_NUMBER : M_IDLE;
            end
            M_STR_FIRST, M_STR:
            begin
                if ((h == 8'h5C) && cv)
                begin
                    p_mode = (mode_reg == M_STR_FIRST) ? M_ESC_FIRST : M_ESC;
                end
                else
                begin
                    p_emit = 1'b1;
                    p_kind = KIND_STRING;
                    p_st   = (mode_reg == M_STR_FIRST);
                    p_en   = ends;
                    p_mode = ends ? (cv ? M_STR_CLOSE : M_IDLE) : M_STR;
                end
            end
            M_ESC_FIRST, M_ESC:
            begin
                p_emit = 1'b1;
                p_kind = KIND_STRING;
                p_st   = (mode_reg == M_ESC_FIRST);
                p_en   = ends;
                p_mode = ends ? (cv ? M_STR_CLOSE : M_IDLE) : M_STR;
            end
            M_STR_CLOSE, M_CMT_CLOSE:
            begin
                p_mode = M_IDLE;
            end
            M_CMT_OPEN:
            begin
                p_mode = M_CMT;
            end
            M_CMT:
            begin
                if ((h == 8'h2A) && cv && (c == 8'h2F))
                begin
                    p_mode = M_CMT_CLOSE;
                end
            end
            default:
            begin
                // A new token starts at the held character.
                p_mode = M_IDLE;
                p_tl   = line_reg;
                p_tc   = col_reg;
                p_st   = 1'b1;
                if ((h == 8'h2F) && cv && (c == 8'h2A))
                begin
                    p_mode = M_CMT_OPEN;
                end
                else if (is_ws(h))
                begin
                    cont   = cv && is_ws(c);
                    p_emit = 1'b1;
                    p_kind = KIND_WS;
                    p_en   = !cont;
                    p_mode = cont ? M_WS : M_IDLE;
                end
                else if (is_id_start(h))
                begin
                    cont   = cv && (is_id_start(c) || is_digit(c));
                    p_emit = 1'b1;
                    p_kind = KIND_IDENT;
                    p_en   = !cont;
                    p_mode = cont ? M_IDENT : M_IDLE;
                end
                else if (is_digit(h)
                         || ((h == 8'h2B) && cv && (is_digit(c) || (c == 8'h2E))))
                begin
                    cont   = cv && (is_digit(c) || (c == 8'h2E));
                    p_emit = 1'b1;
                    p_kind = KIND_NUMBER;
                    p_en   = !cont;
                    p_mode = cont ? M_NUMBER : M_IDLE;
                end
                else if ((h == 8'h22) || (h == 8'h27))
                begin
                    p_quote = h;
                    if (!cv || (c == h))
                    begin
                        // Empty string: a single result without a byte.
                        p_emit = 1'b1;
                        p_kind = KIND_STRING;
                        p_byte = 8'h00;
                        p_has  = 1'b0;
                        p_en   = 1'b1;
                        p_mode = cv ? M_STR_CLOSE : M_IDLE;
                    end
                    else
                    begin
                        p_mode = M_STR_FIRST;
                    end
                end
                else
                begin
                    p_emit = 1'b1;
                    p_kind = delim_kind(h);
                    p_en   = 1'b1;
                end
            end
        endcase
    end

    // Position after consuming the held character.
    always_comb
    begin
        adv_line = line_reg;
        adv_col  = col_reg;
        if (h == 8'h0A)
        begin
            if (line_reg != '1)
            begin
                adv_line = line_reg + POS_ONE;
            end
            adv_col = POS_ONE;
        end
        else if (col_reg != '1)
        begin
            adv_col = col_reg + POS_ONE;
        end
    end

    assign eof_line = held_valid_reg ? adv_line : line_reg;
    assign eof_col  = held_valid_reg ? adv_col : col_reg;

    assign p_res   = '{kind: p_kind, value_byte: p_byte, has_byte: p_has,
                       token_start: p_st, token_end: p_en,
                       start_line: clamp_pos(p_tl), start_column: clamp_pos(p_tc)};
    assign eof_res = '{kind: KIND_EOF, value_byte: 8'h00, has_byte: 1'b0,
                       token_start: 1'b1, token_end: 1'b1,
                       start_line: clamp_pos(eof_line), start_column: clamp_pos(eof_col)};

    always_comb
    begin
        push_data.r0       = (held_valid_reg && p_emit) ? p_res : eof_res;
        push_data.r1_valid = item.end_of_input && held_valid_reg && p_emit;
        push_data.r1       = eof_res;
        push_valid         = fire && (item.end_of_input || (held_valid_reg && p_emit));
    end

    always_comb
    begin
        mode_next       = mode_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        quote_next      = quote_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        tok_line_next   = tok_line_reg;
        tok_col_next    = tok_col_reg;
        if (fire)
        begin
            if (item.end_of_input)
            begin
                // The stream closes: back to the reset state for a new one.
                mode_next       = M_IDLE;
                held_next       = 8'h00;
                held_valid_next = 1'b0;
                quote_next      = 8'h00;
                line_next       = POS_ONE;
                col_next        = POS_ONE;
                tok_line_next   = POS_ONE;
                tok_col_next    = POS_ONE;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    mode_next     = p_mode;
                    quote_next    = p_quote;
                    line_next     = adv_line;
                    col_next      = adv_col;
                    tok_line_next = p_tl;
                    tok_col_next  = p_tc;
                end
                held_next       = item.ch;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            quote_reg      <= 8'h00;
            line_reg       <= POS_ONE;
            col_reg        <= POS_ONE;
            tok_line_reg   <= POS_ONE;
            tok_col_reg    <= POS_ONE;
        end
        else
        begin
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            quote_reg      <= quote_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            tok_line_reg   <= tok_line_next;
            tok_col_reg    <= tok_col_next;
        end
    end

endmodule

### design/csstl_queue.sv
module csstl_queue
    import csstl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  rec_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output rec_t pop_data
);

    localparam logic [QCNT_WIDTH-1:0] CNT_FULL = QCNT_WIDTH'(QUEUE_DEPTH);
    localparam logic [QPTR_WIDTH-1:0] PTR_LAST = QPTR_WIDTH'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_WIDTH-1:0] PTR_ONE  = QPTR_WIDTH'(1);
    localparam logic [QCNT_WIDTH-1:0] CNT_ONE  = QCNT_WIDTH'(1);

    rec_t                  mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/csstl_back.sv
module csstl_back
    import csstl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  rec_t    pop_data,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic    a_valid_reg, a_valid_next;
    logic    b_valid_reg, b_valid_next;
    result_t a_reg, a_next;
    result_t b_reg, b_next;
    logic    out_fire;

    assign result_valid = a_valid_reg;
    assign result       = a_reg;
    assign out_fire     = result_valid && result_ready;
    // A record is loaded once the second slot is empty and the output slot frees.
    assign pop_ready    = !a_valid_reg || (out_fire && !b_valid_reg);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (out_fire && b_valid_reg)
        begin
            a_next       = b_reg;
            b_valid_next = 1'b0;
        end
        else if (pop_valid && pop_ready)
        begin
            a_next       = pop_data.r0;
            a_valid_next = 1'b1;
            b_next       = pop_data.r1;
            b_valid_next = pop_data.r1_valid;
        end
        else if (out_fire)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

endmodule

### design/css_token_lexer.sv
// Streaming CSS tokenizer. Characters arrive one per transfer on the item
// channel; an item with end_of_input set closes the stream, flushes the open
// token, adds an end-of-file token and returns the block to its reset state.
// Each result transfer carries at most one value byte of a token with its
// kind, start and end marks and the line and column where the token began.
// The block holds one character of lookahead, so the results for a character
// appear only after the next item (or the end item) has been taken. The front
// end classifies one character per clock cycle and writes the results it
// causes (none, one, or two on an end item) as one record into a four-entry
// queue; the back end drains one result per clock cycle through its output
// register. A new item is accepted every cycle as long as the queue has room,
// so the sustained rate is one character per cycle whenever each character
// yields at most one result and the consumer keeps result_ready high.
module css_token_lexer
    import csstl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic push_valid, push_ready;
    rec_t push_data;
    logic pop_valid, pop_ready;
    rec_t pop_data;

    // Front end: lookahead register, lexer mode and position counters.
    csstl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Record queue that lets the front end run ahead of a stalled consumer.
    csstl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: splits each record into single result transfers.
    csstl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
